@@ src/lidar_point_to_table_coords_unit_assert.svh @@
`ifndef LIDAR_POINT_TO_TABLE_COORDS_UNIT_ASSERT_SVH
`define LIDAR_POINT_TO_TABLE_COORDS_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ptc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  localparam int RANGE_BITS = 14;
  localparam int COORD_BITS = 16;

  localparam int ANG_W     = 13;
  localparam int POS_W     = 13;
  localparam int MARGIN_W  = 11;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam int FULL_TURN = 5760;
  localparam int QUARTER   = 1440;
  localparam int ANG_SUM_W = ANG_W + 1;
  localparam int ADDR_W    = 11;

  localparam int SIN_W     = 15;
  localparam int TRIG_W    = SIN_W + 1;
  localparam int FRAC_BITS = 15;

  localparam int HALF_X = 1150;
  localparam int HALF_Y = 1650;

  localparam int PROD_W  = RANGE_BITS + 1 + TRIG_W;
  localparam int OFS_W   = POS_W + FRAC_BITS;
  localparam int SUM_W   = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 1;
  localparam int PX_W    = SUM_W - FRAC_BITS;
  localparam int CMP_W0  = (PX_W > COORD_BITS) ? PX_W : COORD_BITS;
  localparam int CMP_W   = ((CMP_W0 > MARGIN_W + 2) ? CMP_W0 : MARGIN_W + 2) + 1;

  localparam int NUM_STAGES  = 6;
  localparam int IN_TDATA_W  = ((RANGE_BITS + ANG_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8;

  localparam longint unsigned Q30_ONE  = 64'd1073741824;
  localparam longint unsigned STEP_Q30 = 64'd1171271;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROBOT_X,
    REG_ROBOT_Y,
    REG_HEADING,
    REG_MARGIN
  } cfg_reg_e;

  typedef struct packed {
    logic wrap;
    logic split;
  } angle_en_t;

  typedef struct packed {
    logic mult;
    logic add;
    logic outp;
  } axis_en_t;

  typedef struct packed {
    logic [SIN_W-1:0] mag;
    logic             neg;
  } trig_t;

  // first-quadrant sine in Q15, t in 1/16 degree
  function automatic logic [SIN_W-1:0] sin_entry(int t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned v;
    x  = longint'(t) * STEP_Q30;
    x2 = (x * x) >> 30;
    p  = Q30_ONE - (((x2 * Q30_ONE) >> 30) / 64'd110);
    p  = Q30_ONE - (((x2 * p) >> 30) / 64'd72);
    p  = Q30_ONE - (((x2 * p) >> 30) / 64'd42);
    p  = Q30_ONE - (((x2 * p) >> 30) / 64'd20);
    p  = Q30_ONE - (((x2 * p) >> 30) / 64'd6);
    v  = (x * p) >> 30;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SIN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/ptc_angle.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptc_angle
  import ptc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire angle_en_t           en_i,
  input  wire logic [ANG_W-1:0]    bearing_i,
  input  wire logic [ANG_W-1:0]    heading_i,
  output quad_e                    quad_o,
  output logic      [ADDR_W-1:0]   addr_a_o,
  output logic      [ADDR_W-1:0]   addr_b_o
);

  localparam logic [ANG_SUM_W-1:0] TURN1 = ANG_SUM_W'(FULL_TURN);
  localparam logic [ANG_SUM_W-1:0] TURN2 = ANG_SUM_W'(2 * FULL_TURN);
  localparam logic [ANG_W-1:0]     QTR1  = ANG_W'(QUARTER);
  localparam logic [ANG_W-1:0]     QTR2  = ANG_W'(2 * QUARTER);
  localparam logic [ANG_W-1:0]     QTR3  = ANG_W'(3 * QUARTER);
  localparam logic [ADDR_W-1:0]    QTR_A = ADDR_W'(QUARTER);

  logic [ANG_SUM_W-1:0] sum;
  logic [ANG_W-1:0]     ang_d, ang_q;
  quad_e                quad_d, quad_q;
  logic [ADDR_W-1:0]    off_d, off_q;
  logic [ADDR_W-1:0]    comp_q;

  always_comb begin
    sum = {1'b0, bearing_i} + {1'b0, heading_i};
    if (sum >= TURN2) begin
      ang_d = ANG_W'(sum - TURN2);
    end else if (sum >= TURN1) begin
      ang_d = ANG_W'(sum - TURN1);
    end else begin
      ang_d = ANG_W'(sum);
    end
  end

  always_comb begin
    if (ang_q >= QTR3) begin
      quad_d = QUAD_3;
      off_d  = ADDR_W'(ang_q - QTR3);
    end else if (ang_q >= QTR2) begin
      quad_d = QUAD_2;
      off_d  = ADDR_W'(ang_q - QTR2);
    end else if (ang_q >= QTR1) begin
      quad_d = QUAD_1;
      off_d  = ADDR_W'(ang_q - QTR1);
    end else begin
      quad_d = QUAD_0;
      off_d  = ADDR_W'(ang_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.wrap) begin
      ang_q <= ang_d;
    end
    if (en_i.split) begin
      quad_q <= quad_d;
      off_q  <= off_d;
      comp_q <= QTR_A - off_d;
    end
  end

  assign quad_o   = quad_q;
  assign addr_a_o = off_q;
  assign addr_b_o = comp_q;

endmodule

`default_nettype wire

@@ src/ptc_sine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptc_sine
  import ptc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire quad_e              quad_i,
  input  wire logic [ADDR_W-1:0]  addr_a_i,
  input  wire logic [ADDR_W-1:0]  addr_b_i,
  output trig_t                   cos_o,
  output trig_t                   sin_o
);

  logic [SIN_W-1:0] sin_rom [QUARTER+1];
  logic [SIN_W-1:0] sa_q, sb_q;
  quad_e            quad_q;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign sin_rom[g] = sin_entry(g);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= sin_rom[addr_a_i];
      sb_q   <= sin_rom[addr_b_i];
      quad_q <= quad_i;
    end
  end

  always_comb begin
    case (quad_q)
      QUAD_0: begin
        cos_o = '{mag: sb_q, neg: 1'b0};
        sin_o = '{mag: sa_q, neg: 1'b0};
      end
      QUAD_1: begin
        cos_o = '{mag: sa_q, neg: 1'b1};
        sin_o = '{mag: sb_q, neg: 1'b0};
      end
      QUAD_2: begin
        cos_o = '{mag: sb_q, neg: 1'b1};
        sin_o = '{mag: sa_q, neg: 1'b1};
      end
      QUAD_3: begin
        cos_o = '{mag: sa_q, neg: 1'b0};
        sin_o = '{mag: sb_q, neg: 1'b1};
      end
      default: begin
        cos_o = '{mag: sb_q, neg: 1'b0};
        sin_o = '{mag: sa_q, neg: 1'b0};
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/ptc_axis.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptc_axis
  import ptc_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire axis_en_t                     en_i,
  input  wire logic        [RANGE_BITS-1:0] range_i,
  input  wire trig_t                        trig_i,
  input  wire logic signed [POS_W-1:0]      offset_i,
  input  wire logic        [MARGIN_W-1:0]   half_i,
  input  wire logic        [MARGIN_W-1:0]   margin_i,
  input  wire logic                         point_valid_i,
  output logic signed      [COORD_BITS-1:0] coord_o,
  output logic                              inside_o
);

  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [CMP_W-1:0] COORD_MAX  =
    CMP_W'((longint'(1) << (COORD_BITS - 1)) - 1);
  localparam logic signed [CMP_W-1:0] COORD_MIN  = -COORD_MAX - CMP_W'(1);

  logic signed [TRIG_W-1:0]     trig_val;
  logic signed [RANGE_BITS:0]   range_s;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [SUM_W-1:0]      sum, sum_b;
  logic signed [PX_W-1:0]       px_q;
  logic signed [CMP_W-1:0]      px_e, lim_hi, lim_lo;
  logic signed [COORD_BITS-1:0] coord_d, coord_q;
  logic                         inside_d, inside_q;

  always_comb begin
    range_s  = $signed({1'b0, range_i});
    trig_val = trig_i.neg ? -$signed({1'b0, trig_i.mag}) : $signed({1'b0, trig_i.mag});
  end

  always_comb begin
    sum   = SUM_W'(prod_q) + (SUM_W'(offset_i) <<< FRAC_BITS);
    sum_b = sum[SUM_W-1] ? sum + TRUNC_BIAS : sum;
  end

  always_comb begin
    px_e     = CMP_W'(px_q);
    lim_hi   = $signed(CMP_W'(half_i)) - $signed(CMP_W'(margin_i));
    lim_lo   = $signed(CMP_W'(margin_i)) - $signed(CMP_W'(half_i));
    inside_d = (px_e < lim_hi) && (px_e > lim_lo);
    if (px_e > COORD_MAX) begin
      coord_d = COORD_MAX[COORD_BITS-1:0];
    end else if (px_e < COORD_MIN) begin
      coord_d = COORD_MIN[COORD_BITS-1:0];
    end else begin
      coord_d = px_e[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mult) begin
      prod_q <= range_s * trig_val;
    end
    if (en_i.add) begin
      px_q <= sum_b[SUM_W-1:FRAC_BITS];
    end
    if (en_i.outp) begin
      coord_q  <= point_valid_i ? coord_d : '0;
      inside_q <= point_valid_i & inside_d;
    end
  end

  assign coord_o  = coord_q;
  assign inside_o = inside_q;

endmodule

`default_nettype wire

@@ src/lidar_point_to_table_coords_unit.sv @@
// Channel   Direction  Ports           Contents
// s_axis    in         tdata           range_mm, bearing
//                      tuser           point_valid
//                      tlast           last_point
// m_axis    out        tdata           table_x, table_y, on_table
//                      tuser           valid_out
//                      tlast           last_out
// cfg       in         we / idx / data robot_x, robot_y, robot_heading, table_margin
//
// One transaction per cycle sustained while m_axis_tready stays high; six register
// stages, the last of them the output register.
// Stages: heading wrap, quadrant split, sine ROM read (two ports), multiply, offset and
// truncate, saturate and bounds check.
// Reset clears valid bits and configuration; no clearing pass, the sine ROM is constant.
// Backpressure chains combinationally through the stage readies: an empty stage keeps loading, so bubbles collapse.
`timescale 1ns / 1ps
`default_nettype none

module lidar_point_to_table_coords_unit
  import ptc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,

  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // range_mm, bearing, zero pad
  input  wire logic                   s_axis_tuser,   // point_valid
  input  wire logic                   s_axis_tlast,

  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // table_x, table_y, on_table, zero pad
  output logic                        m_axis_tuser,   // valid_out
  output logic                        m_axis_tlast
);

  localparam logic signed [COORD_BITS-1:0] X_LIM  = COORD_BITS'(HALF_X);
  localparam logic signed [COORD_BITS-1:0] X_NLIM = -X_LIM;
  localparam logic signed [COORD_BITS-1:0] Y_LIM  = COORD_BITS'(HALF_Y);
  localparam logic signed [COORD_BITS-1:0] Y_NLIM = -Y_LIM;
  localparam logic        [MARGIN_W-1:0]   HX     = MARGIN_W'(HALF_X);
  localparam logic        [MARGIN_W-1:0]   HY     = MARGIN_W'(HALF_Y);

  logic signed [POS_W-1:0]      robot_x_q, robot_y_q;
  logic        [ANG_W-1:0]      heading_q;
  logic        [MARGIN_W-1:0]   margin_q;

  logic [NUM_STAGES-1:0]        v_q, rdy, pv_q, last_q;
  logic [RANGE_BITS-1:0]        range1_q, range2_q, range3_q;

  angle_en_t                    angle_en;
  axis_en_t                     axis_en;
  quad_e                        quad;
  logic [ADDR_W-1:0]            addr_a, addr_b;
  trig_t                        cos_t, sin_t;
  logic signed [COORD_BITS-1:0] coord_x, coord_y;
  logic                         inside_x, inside_y, on_table;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q <= '0;
      robot_y_q <= '0;
      heading_q <= '0;
      margin_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROBOT_X: robot_x_q <= cfg_data_i[POS_W-1:0];
        REG_ROBOT_Y: robot_y_q <= cfg_data_i[POS_W-1:0];
        REG_HEADING: heading_q <= cfg_data_i[ANG_W-1:0];
        REG_MARGIN:  margin_q  <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (rdy & {v_q[NUM_STAGES-2:0], s_axis_tvalid}) | (~rdy & v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q   <= (rdy & {pv_q[NUM_STAGES-2:0], s_axis_tuser}) | (~rdy & pv_q);
    last_q <= (rdy & {last_q[NUM_STAGES-2:0], s_axis_tlast}) | (~rdy & last_q);
    if (rdy[0]) begin
      range1_q <= s_axis_tdata[RANGE_BITS-1:0];
    end
    if (rdy[1]) begin
      range2_q <= range1_q;
    end
    if (rdy[2]) begin
      range3_q <= range2_q;
    end
  end

  assign angle_en = '{wrap: rdy[0], split: rdy[1]};
  assign axis_en  = '{mult: rdy[3], add: rdy[4], outp: rdy[5]};

  ptc_angle u_angle (
    .clk_i     (clk_i),
    .en_i      (angle_en),
    .bearing_i (s_axis_tdata[RANGE_BITS +: ANG_W]),
    .heading_i (heading_q),
    .quad_o    (quad),
    .addr_a_o  (addr_a),
    .addr_b_o  (addr_b)
  );

  ptc_sine u_sine (
    .clk_i    (clk_i),
    .en_i     (rdy[2]),
    .quad_i   (quad),
    .addr_a_i (addr_a),
    .addr_b_i (addr_b),
    .cos_o    (cos_t),
    .sin_o    (sin_t)
  );

  ptc_axis u_axis_x (
    .clk_i         (clk_i),
    .en_i          (axis_en),
    .range_i       (range3_q),
    .trig_i        (cos_t),
    .offset_i      (robot_x_q),
    .half_i        (HX),
    .margin_i      (margin_q),
    .point_valid_i (pv_q[NUM_STAGES-2]),
    .coord_o       (coord_x),
    .inside_o      (inside_x)
  );

  ptc_axis u_axis_y (
    .clk_i         (clk_i),
    .en_i          (axis_en),
    .range_i       (range3_q),
    .trig_i        (sin_t),
    .offset_i      (robot_y_q),
    .half_i        (HY),
    .margin_i      (margin_q),
    .point_valid_i (pv_q[NUM_STAGES-2]),
    .coord_o       (coord_y),
    .inside_o      (inside_y)
  );

  assign on_table      = inside_x & inside_y;
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NUM_STAGES-1];
  assign m_axis_tuser  = pv_q[NUM_STAGES-1];
  assign m_axis_tlast  = last_q[NUM_STAGES-1];
  assign m_axis_tdata  = OUT_TDATA_W'({on_table, coord_y, coord_x});

`include "lidar_point_to_table_coords_unit_assert.svh"

  `PTC_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && !m_axis_tuser,
                  m_axis_tdata == '0, "invalid point carries nonzero data")

  `PTC_ASSERT_NOW(a_on_table_bounds, m_axis_tvalid && on_table,
                  (coord_x < X_LIM) && (coord_x > X_NLIM) &&
                  (coord_y < Y_LIM) && (coord_y > Y_NLIM), "on_table set outside table")

  `PTC_ASSERT_NOW(a_stall_source, !s_axis_tready, m_axis_tvalid && !m_axis_tready,
                  "input stalled without output backpressure")

  `PTC_ASSERT_NEXT(a_last_stage_moves, v_q[NUM_STAGES-2] && rdy[NUM_STAGES-1],
                   m_axis_tvalid, "item lost before output register")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ptc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                   valid;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic                   on_tbl;
    logic                   last;
  } point_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_e;

  class coord_scoreboard;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [ANG_W-1:0]        heading;
    logic [MARGIN_W-1:0]     margin;
    int                      sine_tab [QUARTER+1];
    point_t                  expected_points [$];
    int                      mismatches;
    int                      results;
    int                      accepted;
    int                      valid_points;
    int                      inside_points;

    function new();
      for (int t = 0; t <= QUARTER; t++) begin
        sine_tab[t] = quarter_sine(t);
      end
      pos_x = '0;
      pos_y = '0;
      heading = '0;
      margin = '0;
      mismatches = 0;
      results = 0;
      accepted = 0;
      valid_points = 0;
      inside_points = 0;
    endfunction

    // series sine over the first quadrant, Q30 internally, rounded to Q15
    function int quarter_sine(int t);
      longint unsigned dv [5];
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned v;
      dv = '{110, 72, 42, 20, 6};
      x = t;
      x = x * STEP_Q30;
      x2 = (x * x) >> 30;
      p = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
        p = Q30_ONE - (((x2 * p) >> 30) / dv[i]);
      end
      v = (x * p) >> 30;
      v = (v + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return int'(v);
    endfunction

    function logic [COORD_BITS-1:0] clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        v = hi;
      end else if (v < lo) begin
        v = lo;
      end
      return v[COORD_BITS-1:0];
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_ROBOT_X: pos_x = value[POS_W-1:0];
        REG_ROBOT_Y: pos_y = value[POS_W-1:0];
        REG_HEADING: heading = value[ANG_W-1:0];
        REG_MARGIN:  margin = value[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_point(logic valid, logic [RANGE_BITS-1:0] range_mm,
                                logic [ANG_W-1:0] bearing, logic last);
      point_t e;
      int     angle;
      int     rem;
      int     sa;
      int     sb;
      int     sn;
      int     cs;
      longint rng;
      longint px;
      longint py;
      longint m;
      e.valid = valid;
      e.last = last;
      e.x = '0;
      e.y = '0;
      e.on_tbl = 1'b0;
      accepted++;
      if (valid) begin
        valid_points++;
        angle = (int'(bearing) + int'(heading)) % FULL_TURN;
        rem = angle % QUARTER;
        sa = sine_tab[rem];
        sb = sine_tab[QUARTER - rem];
        case (quad_e'(angle / QUARTER))
          QUAD_0: begin
            sn = sa;
            cs = sb;
          end
          QUAD_1: begin
            sn = sb;
            cs = -sa;
          end
          QUAD_2: begin
            sn = -sa;
            cs = -sb;
          end
          default: begin
            sn = -sb;
            cs = sa;
          end
        endcase
        rng = range_mm;
        px = (rng * cs + longint'(pos_x) * 32768) / 32768;
        py = (rng * sn + longint'(pos_y) * 32768) / 32768;
        m = margin;
        e.on_tbl = (px < HALF_X - m) && (px > m - HALF_X) &&
                   (py < HALF_Y - m) && (py > m - HALF_Y);
        e.x = clamp_coord(px);
        e.y = clamp_coord(py);
        if (e.on_tbl) begin
          inside_points++;
        end
      end
      expected_points.push_back(e);
    endfunction

    task report(string field, longint got, longint want);
      mismatches++;
      if (mismatches <= 20) begin
        $display("point %0d: %s is %0d, expected %0d", results, field, got, want);
      end
    endtask

    task check_point(logic [OUT_TDATA_W-1:0] data, logic user, logic lst);
      point_t e;
      results++;
      if (expected_points.size() == 0) begin
        report("unexpected point, pending count", 0, 0);
        return;
      end
      e = expected_points.pop_front();
      if (user !== e.valid) begin
        report("valid_out", user, e.valid);
      end
      if (data[COORD_BITS-1:0] !== e.x) begin
        report("table_x", longint'($signed(data[COORD_BITS-1:0])), longint'($signed(e.x)));
      end
      if (data[2*COORD_BITS-1:COORD_BITS] !== e.y) begin
        report("table_y", longint'($signed(data[2*COORD_BITS-1:COORD_BITS])),
               longint'($signed(e.y)));
      end
      if (data[2*COORD_BITS] !== e.on_tbl) begin
        report("on_table", data[2*COORD_BITS], e.on_tbl);
      end
      if (lst !== e.last) begin
        report("last_out", lst, e.last);
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    s_axis_tlast;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;

  coord_scoreboard sb;
  int              cycle_count = 0;
  int              burst_left = 0;
  int              settings_used = 1;
  ready_mode_e     ready_mode = READY_ALWAYS;
  int              ready_left = 0;

  lidar_point_to_table_coords_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(20, 120);
    end else begin
      ready_left = ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:   m_axis_tready <= 1'b1;
      READY_COIN:     m_axis_tready <= $urandom_range(0, 1);
      READY_PERIODIC: m_axis_tready <= (cycle_count % 4) != 3;
      default:        m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_point(logic valid, logic [RANGE_BITS-1:0] range_mm,
                            logic [ANG_W-1:0] bearing, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - RANGE_BITS - ANG_W){1'b0}}, bearing, range_mm};
    s_axis_tuser <= valid;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_point(valid, range_mm, bearing, last);
    burst_left = burst_left - 1;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic set_pose(logic [CFG_W-1:0] px, logic [CFG_W-1:0] py,
                          logic [CFG_W-1:0] hd, logic [CFG_W-1:0] mg);
    write_reg(REG_ROBOT_X, px);
    write_reg(REG_ROBOT_Y, py);
    write_reg(REG_HEADING, hd);
    write_reg(REG_MARGIN, mg);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  function automatic logic [RANGE_BITS-1:0] pick_range();
    if ($urandom_range(0, 9) < 6) begin
      return $urandom_range(0, 2500);
    end
    return $urandom_range(0, (1 << RANGE_BITS) - 1);
  endfunction

  task automatic run_scans(int count);
    int                    n;
    int                    start;
    int                    step;
    bit                    closed;
    logic [ANG_W-1:0]      brg;
    while (count > 0) begin
      n = $urandom_range(4, 48);
      if (n > count) begin
        n = count;
      end
      start = $urandom_range(0, FULL_TURN - 1);
      step = $urandom_range(1, 64);
      closed = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_point($urandom_range(0, 1), $urandom_range(0, (1 << RANGE_BITS) - 1),
                     $urandom_range(0, (1 << ANG_W) - 1), $urandom_range(0, 1));
        end else begin
          if ($urandom_range(0, 19) == 0) begin
            brg = $urandom_range(FULL_TURN, (1 << ANG_W) - 1);
          end else begin
            brg = (start + i * step) % FULL_TURN;
          end
          send_point($urandom_range(0, 15) != 0, pick_range(), brg,
                     closed && (i == n - 1));
        end
      end
      count -= n;
    end
  endtask

  initial begin
    sb = new();
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_ROBOT_X;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(1'b1, 0, 0, 1'b0);
    send_point(1'b1, 16383, 0, 1'b0);
    send_point(1'b1, 1149, 0, 1'b0);
    send_point(1'b1, 1150, 0, 1'b0);
    send_point(1'b1, 1000, 2880, 1'b0);
    send_point(1'b1, 1649, 1440, 1'b0);
    send_point(1'b1, 1651, 1440, 1'b0);
    send_point(1'b1, 5000, 4320, 1'b0);
    send_point(1'b1, 777, 5759, 1'b0);
    send_point(1'b1, 777, 5760, 1'b0);
    send_point(1'b1, 16383, 8191, 1'b0);
    send_point(1'b0, 16383, 1234, 1'b0);
    send_point(1'b0, 0, 0, 1'b1);
    send_point(1'b1, 300, 720, 1'b1);
    send_point(1'b1, 2000, 1439, 1'b0);
    send_point(1'b1, 2000, 1441, 1'b0);
    send_point(1'b1, 2000, 2879, 1'b0);
    send_point(1'b1, 2000, 4319, 1'b0);
    send_point(1'b1, 2000, 4321, 1'b1);

    for (int ph = 0; ph < 11; ph++) begin
      drain();
      case (ph)
        0: set_pose(13'h1000, 13'h1000, 13'h1FFF, 13'h7FF);
        1: set_pose(13'h0FFF, 13'h0FFF, 5759, 1150);
        2: set_pose(0, 0, 0, 1149);
        3: set_pose(0, 0, QUARTER, 0);
        default: set_pose($urandom_range(0, 2400) - 1200, $urandom_range(0, 3400) - 1700,
                          $urandom_range(0, (1 << ANG_W) - 1),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, 300));
      endcase
      run_scans(170);
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (sb.expected_points.size() != 0) begin
      sb.report("points never returned", 0, sb.expected_points.size());
    end
    $display("covered %0d lidar returns (%0d valid, %0d inside the shrunk table)",
             sb.accepted, sb.valid_points, sb.inside_points);
    $display("over %0d pose and margin settings, %0d results checked",
             settings_used, sb.results);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
